/* rtl/core/pfdm_pkg.sv */
// Package: widths, constants and queue entry type for the PWM frequency and duty meter.
`timescale 1ns / 1ps

package pfdm_pkg;

  localparam int CntW       = 20;
  localparam int WindowW    = 20;
  localparam int FreqW      = 19;
  localparam int DutyW      = 10;
  localparam int ProdW      = CntW + DutyW;
  localparam int CmpW       = (CntW > WindowW) ? CntW : WindowW;
  localparam int FreqCmpW   = (CntW > FreqW) ? CntW : FreqW;
  localparam int QueueDepth = 2;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int StepW      = $clog2(DutyW);

  localparam logic [WindowW-1:0] WindowReset   = WindowW'(50000);
  localparam logic [CntW-1:0]    CntMax        = {CntW{1'b1}};
  localparam logic [FreqW-1:0]   FreqMax       = {FreqW{1'b1}};
  localparam logic [DutyW-1:0]   PermilleScale = DutyW'(1000);

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [CntW-1:0]  high;
    logic [CntW-1:0]  samples;
  } window_t;

endpackage

/* rtl/core/pwm_frequency_duty_meter_unit.sv */
// Top level: PWM frequency and duty-cycle meter.
`timescale 1ns / 1ps

// Usage:
//   Input queue side: drive pin_level_i with push; a sample transfers at a
//   clock edge with push high and full low. One sample per clock is taken while full is low.
//   Result queue side: while empty is low, frequency_o and duty_permille_o
//   hold the oldest result; it transfers at an edge with pop high.
//   A result is produced for the sample that closes a window of
//   window_samples samples (zero acts as one).
//   cfg_we_i/cfg_wdata_i write window_samples; write only while idle.
// Result path: the closing window is queued, dequeued, multiplied by 1000
//   and divided in 10 restoring-division steps.
// Flow: one sample per cycle while full is low; the back divider takes a
//   new window only after the previous result is popped. A two-entry
//   window queue lets the front keep sampling while the back part works.
// Reset: window_samples returns to 50000, counters and previous level clear,
//   queue and result register empty.
// Stall: when pop is held low the result stays; the front keeps sampling
//   until two closed windows are queued, then full rises.

module pwm_frequency_duty_meter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pfdm_pkg::WindowW-1:0] cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic                        pin_level_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [pfdm_pkg::FreqW-1:0]  frequency_o,
  output logic [pfdm_pkg::DutyW-1:0]  duty_permille_o
);
  import pfdm_pkg::*;

  logic    sample_valid;
  logic    win_valid;
  window_t win_wr, win_rd;
  logic    q_empty, q_pop;

  assign sample_valid = push && !full;

  pfdm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_valid_i (sample_valid),
    .pin_level_i    (pin_level_i),
    .win_valid_o    (win_valid),
    .win_o          (win_wr)
  );

  pfdm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (win_valid),
    .wr_data_i (win_wr),
    .full_o    (full),
    .rd_en_i   (q_pop),
    .empty_o   (q_empty),
    .rd_data_o (win_rd)
  );

  pfdm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .win_empty_i     (q_empty),
    .win_i           (win_rd),
    .win_pop_o       (q_pop),
    .empty           (empty),
    .pop             (pop),
    .frequency_o     (frequency_o),
    .duty_permille_o (duty_permille_o)
  );

endmodule

/* rtl/core/pfdm_front.sv */
// Front part: sample counting, window close detection and frequency saturation.
`timescale 1ns / 1ps

module pfdm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfdm_pkg::WindowW-1:0]  cfg_wdata_i,
  input  logic                          sample_valid_i,
  input  logic                          pin_level_i,
  output logic                          win_valid_o,
  output pfdm_pkg::window_t             win_o
);
  import pfdm_pkg::*;

  logic [WindowW-1:0] window_q;
  logic               prev_q;
  logic [CntW-1:0]    samples_q, samples_d;
  logic [CntW-1:0]    high_q, high_d;
  logic [CntW-1:0]    chg_q, chg_d;
  logic               close;
  logic [FreqCmpW-1:0] freq_wide;

  always_comb begin
    samples_d = samples_q + CntW'(1);
    high_d    = high_q + CntW'(pin_level_i);
    chg_d     = chg_q + CntW'(pin_level_i ^ prev_q);
    close     = (CmpW'(samples_d) >= CmpW'(window_q)) || (samples_d == CntMax);
    freq_wide = FreqCmpW'(chg_d >> 1);
  end

  assign win_valid_o  = sample_valid_i && close;
  assign win_o.high    = high_d;
  assign win_o.samples = samples_d;
  assign win_o.freq    = (freq_wide > FreqCmpW'(FreqMax)) ? FreqMax : FreqW'(freq_wide);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WindowReset;
      prev_q    <= 1'b0;
      samples_q <= '0;
      high_q    <= '0;
      chg_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (sample_valid_i) begin
        prev_q <= pin_level_i;
        if (close) begin
          samples_q <= '0;
          high_q    <= '0;
          chg_q     <= '0;
        end else begin
          samples_q <= samples_d;
          high_q    <= high_d;
          chg_q     <= chg_d;
        end
      end
    end
  end

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid_o |=> (samples_q == '0) && (high_q == '0) && (chg_q == '0))
    else $error("counters not cleared after window close");

  a_high_le_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (high_q <= samples_q) && (chg_q <= samples_q))
    else $error("counter ordering violated");

endmodule

/* rtl/core/pfdm_queue.sv */
// Short queue of closed windows between front and back parts.
`timescale 1ns / 1ps

module pfdm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  pfdm_pkg::window_t   wr_data_i,
  output logic                full_o,
  input  logic                rd_en_i,
  output logic                empty_o,
  output pfdm_pkg::window_t   rd_data_o
);
  import pfdm_pkg::*;

  window_t           mem_q [QueueDepth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [QCntW-1:0]  count_q;
  logic              do_wr, do_rd;

  assign full_o    = (count_q == QCntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + QCntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QueueDepth))
    else $error("queue count out of range");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> count_q == $past(count_q) + QCntW'(1))
    else $error("queue transfer lost");

endmodule

/* rtl/core/pfdm_back.sv */
// Back part: duty computation by a single restoring divider and the result register.
`timescale 1ns / 1ps

module pfdm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        win_empty_i,
  input  pfdm_pkg::window_t           win_i,
  output logic                        win_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [pfdm_pkg::FreqW-1:0]  frequency_o,
  output logic [pfdm_pkg::DutyW-1:0]  duty_permille_o
);
  import pfdm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_HOLD
  } state_e;

  state_e            state_q;
  logic [FreqW-1:0]  freq_q;
  logic [CntW-1:0]   high_q;
  logic [CntW-1:0]   samples_q;
  logic [ProdW-1:0]  rem_q, dsh_q;
  logic [DutyW-1:0]  quo_q;
  logic [StepW-1:0]  step_q;
  logic              ge;

  assign win_pop_o       = (state_q == S_IDLE) && !win_empty_i;
  assign empty           = (state_q != S_HOLD);
  assign frequency_o     = freq_q;
  assign duty_permille_o = quo_q;
  assign ge              = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      freq_q    <= '0;
      high_q    <= '0;
      samples_q <= '0;
      rem_q     <= '0;
      dsh_q     <= '0;
      quo_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (!win_empty_i) begin
            freq_q    <= win_i.freq;
            high_q    <= win_i.high;
            samples_q <= win_i.samples;
            state_q   <= S_MUL;
          end
        end
        S_MUL: begin
          rem_q   <= ProdW'(high_q) * ProdW'(PermilleScale);
          dsh_q   <= ProdW'(samples_q) << (DutyW - 1);
          step_q  <= StepW'(DutyW - 1);
          quo_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            rem_q <= rem_q - dsh_q;
          end
          quo_q <= {quo_q[DutyW-2:0], ge};
          dsh_q <= dsh_q >> 1;
          if (step_q == '0) begin
            state_q <= S_HOLD;
          end else begin
            step_q <= step_q - StepW'(1);
          end
        end
        S_HOLD: begin
          if (pop) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> duty_permille_o <= PermilleScale)
    else $error("duty out of range");

  a_hold_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_HOLD) |-> $past(state_q == S_DIV) && $past(step_q == '0))
    else $error("result shown before division finished");

endmodule

/* sim/testbench.sv */
// Testbench: random and directed pin samples through the PWM meter, checked against a window model.
`timescale 1ns / 1ps

module testbench;
  import pfdm_pkg::*;

  localparam int HoldCycles   = 400;
  localparam int StallLimit   = 4000;
  localparam int DrainCycles  = 30;
  localparam int RandomItems  = 1700;
  localparam int CalmAfter    = 1450;
  localparam int PressureAt   = 600;

  typedef enum int {
    PAT_PWM,
    PAT_RANDOM,
    PAT_CONST,
    PAT_TOGGLE
  } pattern_e;

  class window_scoreboard;
    typedef struct {
      logic [FreqW-1:0] freq;
      logic [DutyW-1:0] duty;
    } reading_t;

    logic [WindowW-1:0] window_len;
    bit                 prev_level;
    longint unsigned    n_samples;
    longint unsigned    n_high;
    longint unsigned    n_changes;
    reading_t           expected_q[$];
    int unsigned        errors;
    int unsigned        readings_checked;

    function new();
      window_len       = WindowReset;
      prev_level       = 1'b0;
      n_samples        = 0;
      n_high           = 0;
      n_changes        = 0;
      errors           = 0;
      readings_checked = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(bit level);
      reading_t        r;
      longint unsigned f;
      n_samples++;
      n_high    += level;
      n_changes += (level ^ prev_level);
      prev_level = level;
      if (n_samples < longint'(window_len) && n_samples < longint'(CntMax)) return;
      f = n_changes >> 1;
      if (f > longint'(FreqMax)) f = longint'(FreqMax);
      r.freq = f[FreqW-1:0];
      r.duty = DutyW'((n_high * 1000) / n_samples);
      expected_q.push_back(r);
      n_samples = 0;
      n_high    = 0;
      n_changes = 0;
    endfunction

    function void check_result(logic [FreqW-1:0] freq, logic [DutyW-1:0] duty);
      reading_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: frequency %0d duty_permille %0d", freq, duty);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      readings_checked++;
      if (freq !== r.freq) begin
        $error("frequency: expected %0d, actual %0d", r.freq, freq);
        errors++;
      end
      if (duty !== r.duty) begin
        $error("duty_permille: expected %0d, actual %0d", r.duty, duty);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [WindowW-1:0]  cfg_wdata_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic                pin_level_i = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [FreqW-1:0]    frequency_o;
  logic [DutyW-1:0]    duty_permille_o;

  window_scoreboard    sb = new();
  bit                  calm = 1'b0;
  bit                  hold_request = 1'b0;
  bit                  hold_done = 1'b0;
  int unsigned         samples_sent = 0;
  int unsigned         configs_written = 0;
  int unsigned         stall_cycles = 0;

  pwm_frequency_duty_meter_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .push            (push),
    .full            (full),
    .pin_level_i     (pin_level_i),
    .empty           (empty),
    .pop             (pop),
    .frequency_o     (frequency_o),
    .duty_permille_o (duty_permille_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("timeout: no transfer for %0d cycles", StallLimit);
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_sample(bit level);
    push        <= 1'b1;
    pin_level_i <= level;
    do @(posedge clk_i); while (full);
    sb.note_sample(level);
    samples_sent++;
  endtask

  task automatic pause_sender(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 5));
  endtask

  // Window length is only changed with nothing in flight.
  task automatic write_window(logic [WindowW-1:0] len);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    sb.window_len = len;
    configs_written++;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= WindowW'($urandom());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
        hold_done    = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
        if (!empty) sb.check_result(frequency_o, duty_permille_o);
      end
    end
  end

  initial begin
    int unsigned        phase_len;
    int unsigned        period;
    int unsigned        high_len;
    int unsigned        pick;
    bit                 const_level;
    bit                 level;
    pattern_e           pattern;
    logic [WindowW-1:0] len;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window: nothing closes, first high sample is a change
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
    write_window({WindowW{1'b1}});
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b1);
    // zero length acts as one; the pending partial window closes at once
    write_window('0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    write_window(WindowW'(1));
    send_sample(1'b0);
    send_sample(1'b0);
    write_window(WindowW'(4));
    repeat (4) send_sample(1'b1);
    repeat (4) send_sample(1'b0);
    repeat (2) begin
      send_sample(1'b1);
      send_sample(1'b0);
    end

    while (samples_sent < RandomItems) begin
      if (!hold_done && !hold_request && samples_sent >= PressureAt) begin
        write_window(WindowW'(1));
        hold_request = 1'b1;
        repeat (60) send_sample(1'(($urandom_range(0, 1))));
        continue;
      end
      calm = (samples_sent >= CalmAfter);
      pick = $urandom_range(0, 99);
      if (pick < 60)      len = WindowW'($urandom_range(0, 12));
      else if (pick < 85) len = WindowW'($urandom_range(13, 64));
      else                len = WindowW'($urandom_range(65, 400));
      write_window(len);
      phase_len   = $urandom_range(30, 90) + 2 * len;
      pick        = $urandom_range(0, 99);
      pattern     = (pick < 50) ? PAT_PWM : (pick < 75) ? PAT_RANDOM :
                    (pick < 90) ? PAT_CONST : PAT_TOGGLE;
      period      = $urandom_range(2, 40);
      high_len    = $urandom_range(0, period);
      const_level = 1'($urandom_range(0, 1));
      for (int i = 0; i < phase_len; i++) begin
        case (pattern)
          PAT_PWM:    level = ((i % period) < high_len);
          PAT_RANDOM: level = 1'($urandom_range(0, 1));
          PAT_CONST:  level = const_level;
          default:    level = 1'(i);
        endcase
        maybe_gap();
        send_sample(level);
      end
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d samples over %0d window settings, including zero and full scale",
             samples_sent, configs_written);
    $display("checked %0d readings, input back-pressure exercised", sb.readings_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pfdm_pkg.sv
rtl/core/pfdm_front.sv
rtl/core/pfdm_queue.sv
rtl/core/pfdm_back.sv
rtl/core/pwm_frequency_duty_meter_unit.sv
sim/testbench.sv
